// ===== sv/rabt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rabt_pkg
// Shared types and constants of the ray / box slab test.
// ----------------------------------------------------------------------------
package rabt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 36;             // signed slab numerator, twice scale
  localparam int MAG_W      = 35;             // numerator magnitude
  localparam int DEN_W      = 33;             // 2*|dir|
  localparam int QUO_W      = 32;             // quotient bits kept before saturation
  localparam int REM_W      = DEN_W + QUO_W + 1;
  localparam int DIV_STAGES = QUO_W + 1;      // overflow check, then one bit a stage
  localparam int PIPE_DEPTH = DIV_STAGES + 3; // prep, divider, lane out, result
  localparam int NUM_AXES   = 3;

  localparam logic signed [31:0] T_INF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_SPAN_X   = 3'd3;
  localparam logic [2:0] CFG_SPAN_Y   = 3'd4;
  localparam logic [2:0] CFG_SPAN_Z   = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] t_near;
    logic [30:0] t_far;
  } out_beat_t;

  typedef struct packed {
    logic               miss;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== sv/rabt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rabt_div
// Pipelined unsigned restoring divider: an overflow check, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rabt_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rabt_pkg::MAG_W-1:0] num_mag,
  input  wire logic [rabt_pkg::DEN_W-1:0] den,
  input  wire logic                       neg,
  output logic      [rabt_pkg::QUO_W-1:0] q_mag,
  output logic                            ovf,
  output logic                            neg_o
);
  import rabt_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] q;
    logic             ovf;
    logic             neg;
  } div_stage_t;

  div_stage_t st_r [DIV_STAGES];
  div_stage_t st_nxt [DIV_STAGES];

  // First stage: flag a quotient that does not fit in QUO_W bits.
  always_comb begin
    logic [REM_W-1:0] n;
    n = REM_W'(num_mag) << FRAC_BITS;
    st_nxt[0].rem = n;
    st_nxt[0].den = den;
    st_nxt[0].q   = '0;
    st_nxt[0].ovf = (n >= (REM_W'(den) << QUO_W));
    st_nxt[0].neg = neg;
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
    always_comb begin
      logic [REM_W-1:0] sh;
      sh = REM_W'(st_r[j-1].den) << (QUO_W - j);
      st_nxt[j] = st_r[j-1];
      if (st_r[j-1].rem >= sh) begin
        st_nxt[j].rem         = st_r[j-1].rem - sh;
        st_nxt[j].q[QUO_W-j]  = 1'b1;
      end
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign q_mag = st_r[DIV_STAGES-1].q;
  assign ovf   = st_r[DIV_STAGES-1].ovf;
  assign neg_o = st_r[DIV_STAGES-1].neg;

endmodule
`default_nettype wire

// ===== sv/rabt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rabt_lane
// One axis: slab numerators, two dividers, saturation and ordering.
// ----------------------------------------------------------------------------
module rabt_lane (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] origin,
  input  wire logic signed [31:0] dir,
  input  wire logic signed [31:0] center,
  input  wire logic        [30:0] span,
  output rabt_pkg::lane_res_t     res
);
  import rabt_pkg::*;

  function automatic logic signed [31:0] sat_time(logic [QUO_W-1:0] q, logic o, logic n);
    logic signed [31:0] t;
    if (!n) begin
      t = (o || q[QUO_W-1]) ? T_INF : $signed(q);
    end else begin
      t = (o || q > 32'h8000_0000) ? T_MIN : $signed(32'd0 - q);
    end
    return t;
  endfunction

  logic signed [NUM_W-1:0] num_lo_r, num_hi_r;
  logic signed [31:0]      d_r;
  logic [DIV_STAGES-1:0]   dz_r, ins_r;
  lane_res_t               res_r;

  logic signed [NUM_W-1:0] c2, s, o2;
  logic [MAG_W-1:0]        mag_lo, mag_hi;
  logic [DEN_W-1:0]        dm, den;
  logic                    neg_lo, neg_hi, dz, ins;
  logic [QUO_W-1:0]        q_lo, q_hi;
  logic                    ovf_lo, ovf_hi, ng_lo, ng_hi;

  assign c2 = NUM_W'(center) <<< 1;
  assign s  = $signed(NUM_W'(span));
  assign o2 = NUM_W'(origin) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      num_lo_r <= c2 - s - o2;
      num_hi_r <= c2 + s - o2;
      d_r      <= dir;
    end
  end

  assign mag_lo = num_lo_r[NUM_W-1] ? MAG_W'(-num_lo_r) : MAG_W'(num_lo_r);
  assign mag_hi = num_hi_r[NUM_W-1] ? MAG_W'(-num_hi_r) : MAG_W'(num_hi_r);
  assign dm     = d_r[31] ? (DEN_W'(0) - DEN_W'(d_r)) : DEN_W'(d_r);
  assign den    = {dm[DEN_W-2:0], 1'b0};
  assign neg_lo = num_lo_r[NUM_W-1] ^ d_r[31];
  assign neg_hi = num_hi_r[NUM_W-1] ^ d_r[31];
  assign dz     = (d_r == 32'sd0);
  // Origin inside the slab: low limit <= origin <= high limit.
  assign ins    = (num_lo_r <= 0) && (num_hi_r >= 0);

  rabt_div u_div_lo (
    .clk(clk), .en(en), .num_mag(mag_lo), .den(den), .neg(neg_lo),
    .q_mag(q_lo), .ovf(ovf_lo), .neg_o(ng_lo)
  );
  rabt_div u_div_hi (
    .clk(clk), .en(en), .num_mag(mag_hi), .den(den), .neg(neg_hi),
    .q_mag(q_hi), .ovf(ovf_hi), .neg_o(ng_hi)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r  <= {dz_r[DIV_STAGES-2:0], dz};
      ins_r <= {ins_r[DIV_STAGES-2:0], ins};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] a, b;
    a = sat_time(q_lo, ovf_lo, ng_lo);
    b = sat_time(q_hi, ovf_hi, ng_hi);
    if (en) begin
      if (dz_r[DIV_STAGES-1]) begin
        // Zero direction: neutral times, miss unless inside the slab.
        res_r.miss <= !ins_r[DIV_STAGES-1];
        res_r.ta   <= 32'sd0;
        res_r.tb   <= T_INF;
      end else begin
        res_r.miss <= 1'b0;
        res_r.ta   <= (a > b) ? b : a;
        res_r.tb   <= (a > b) ? a : b;
      end
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== sv/rabt_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rabt_merge
// Combine the axis lanes into near/far times and the hit flag.
// ----------------------------------------------------------------------------
module rabt_merge (
  input  rabt_pkg::lane_res_t res [rabt_pkg::NUM_AXES],
  output rabt_pkg::out_beat_t beat
);
  import rabt_pkg::*;

  always_comb begin
    logic signed [31:0] t0, t1;
    logic               miss;
    t0   = 32'sd0;
    t1   = T_INF;
    miss = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (res[i].ta > t0) t0 = res[i].ta;
      if (res[i].tb < t1) t1 = res[i].tb;
      miss = miss | res[i].miss;
    end
    if (!miss && (t0 <= t1)) begin
      beat.hit    = 1'b1;
      beat.t_near = t0[30:0];
      beat.t_far  = t1[30:0];
    end else begin
      beat.hit    = 1'b0;
      beat.t_near = '0;
      beat.t_far  = '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ray_aabb_slab_test_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one ray per cycle while no result beat is stalled; set by the
// 33-stage pipelined dividers, two per axis.
// The whole pipeline advances together; it holds only while a result beat is stalled.
// Reset (rst_n low, synchronous) clears all stage valid bits and the box registers.
// ----------------------------------------------------------------------------
// ray_aabb_slab_test_top
// Ray versus axis-aligned box slab test, three axis lanes and a merge stage.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  rabt_pkg::in_beat_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rabt_pkg::out_beat_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [31:0]         cfg_data
);
  import rabt_pkg::*;

  // Box registers.
  logic signed [31:0] center_r [NUM_AXES];
  logic        [30:0] span_r   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        center_r[i] <= '0;
        span_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CENTER_X: center_r[0] <= cfg_data;
        CFG_CENTER_Y: center_r[1] <= cfg_data;
        CFG_CENTER_Z: center_r[2] <= cfg_data;
        CFG_SPAN_X:   span_r[0]   <= cfg_data[30:0];
        CFG_SPAN_Y:   span_r[1]   <= cfg_data[30:0];
        CFG_SPAN_Z:   span_r[2]   <= cfg_data[30:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Advance every stage unless the result beat is waiting and stalled.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // One valid bit per pipeline stage; the last one is the result register.
  logic [PIPE_DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Axis lanes.
  logic signed [31:0] org [NUM_AXES];
  logic signed [31:0] dir [NUM_AXES];
  lane_res_t          res [NUM_AXES];

  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rabt_lane u_lane (
      .clk(clk), .en(adv), .origin(org[a]), .dir(dir[a]),
      .center(center_r[a]), .span(span_r[a]), .res(res[a])
    );
  end

  // Merge lanes and hold the result beat.
  out_beat_t merged;
  out_beat_t out_r;

  rabt_merge u_merge (.res(res), .beat(merged));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= merged;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_data  = out_r;

  // Assertions.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.t_near == '0 && out_data.t_far == '0)
    else $error("miss beat with nonzero times");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.t_near <= out_data.t_far)
    else $error("hit beat with near after far");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
